@@ src/svs_pkg.sv @@
// sphere voxel stamper package: types, constants, state enums
// no dependencies
package svs_pkg;
    localparam int MAX_XY = 64;
    localparam int MAX_Z = 32;
    localparam int XW = $clog2(MAX_XY);
    localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int AW = 2 * XW;
    localparam int DEPTH = MAX_XY * MAX_XY;
    localparam int QDEPTH = 2;

    localparam logic [1:0] CMD_STAMP = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic REG_SIZE_XY = 1'b0;
    localparam logic REG_SIZE_Z  = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] ctr_x;
        logic [5:0] ctr_y;
        logic [4:0] ctr_z;
        logic [5:0] radius;
        logic [5:0] probe_x;
        logic [5:0] probe_y;
        logic [4:0] probe_z;
    } t_req;

    typedef struct packed {
        logic voxel_value;
        logic out_of_range;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_STAMP,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // classified job passed from front to back
    typedef struct packed {
        t_op          op;
        logic [XW-1:0] x0;
        logic [XW-1:0] x1;
        logic [XW-1:0] y0;
        logic [XW-1:0] y1;
        logic [XW-1:0] cx;
        logic [XW-1:0] cy;
        logic [ZW-1:0] cz;
        logic [6:0]    r;
        logic [ZW-1:0] z0;
        logic [ZW-1:0] z1;
        logic          oor;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_CALC,
        BK_WR,
        BK_READ,
        BK_CLEAR,
        BK_DONE
    } t_bk_state;
endpackage

@@ src/sphere_voxel_stamper.sv @@
// Voxel occupancy volume with sphere stamp, voxel read and volume clear.
// One request at a time: a stamp walks each clipped (x,y) column through
// BK_RD, BK_CALC and BK_WR, the read-modify-write of the column memory; a read
// passes through BK_READ and BK_DONE; a clear sweeps all 4096 column words, and
// reset runs the same 4096-word sweep during which busy is high. Each request
// gives one strobed result; the result is not held, so the receiver must take it.
// depends on svs_pkg, svs_front, svs_queue, svs_back
module sphere_voxel_stamper import svs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_valid,
    output t_rsp       o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    t_job f_job, q_job;
    logic empty, full, pop, bk_busy, accept;
    logic r_inflight;

    assign accept = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= 1'b0;
        else if (accept) r_inflight <= 1'b1;
        else if (o_valid) r_inflight <= 1'b0;
    end

    assign busy = r_inflight || bk_busy || !empty;

    svs_front u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_req, .o_job(f_job)
    );

    svs_queue u_queue (
        .i_clk, .i_rst_n, .i_push(accept), .i_job(f_job), .i_pop(pop),
        .o_job(q_job), .o_empty(empty), .o_full(full)
    );

    svs_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(q_job), .o_pop(pop),
        .o_busy(bk_busy), .o_done(o_valid), .o_rsp
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && full)) else $error("queue overflow");
    a_done_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight) else $error("result without request");
    a_stamp_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.out_of_range) |-> !o_rsp.voxel_value)
        else $error("out of range read with value");
endmodule

@@ src/svs_front.sv @@
// front end: clamps sizes, clips bounding box, classifies requests
// depends on svs_pkg
module svs_front import svs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  t_req       i_req,
    output t_job       o_job
);
    logic [6:0] r_size_xy;
    logic [5:0] r_size_z;
    logic [6:0] sxy;
    logic [5:0] sz;
    logic signed [8:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [6:0] px, py;
    logic [5:0] pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_xy <= 7'(MAX_XY);
            r_size_z  <= 6'(MAX_Z);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SIZE_XY) r_size_xy <= i_cfg_data;
            else r_size_z <= i_cfg_data[5:0];
        end
    end

    always_comb begin
        sxy = (r_size_xy == '0) ? 7'd1 : (r_size_xy > 7'(MAX_XY)) ? 7'(MAX_XY) : r_size_xy;
        sz  = (r_size_z == '0) ? 6'd1 : (r_size_z > 6'(MAX_Z)) ? 6'(MAX_Z) : r_size_z;
        lo_x = $signed({3'b0, i_req.ctr_x}) - $signed({3'b0, i_req.radius});
        hi_x = $signed({3'b0, i_req.ctr_x}) + $signed({3'b0, i_req.radius});
        lo_y = $signed({3'b0, i_req.ctr_y}) - $signed({3'b0, i_req.radius});
        hi_y = $signed({3'b0, i_req.ctr_y}) + $signed({3'b0, i_req.radius});
        lo_z = $signed({4'b0, i_req.ctr_z}) - $signed({3'b0, i_req.radius});
        hi_z = $signed({4'b0, i_req.ctr_z}) + $signed({3'b0, i_req.radius});
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (lo_z < 0) lo_z = '0;
        if (hi_x > $signed({2'b0, sxy}) - 9'sd1) hi_x = $signed({2'b0, sxy}) - 9'sd1;
        if (hi_y > $signed({2'b0, sxy}) - 9'sd1) hi_y = $signed({2'b0, sxy}) - 9'sd1;
        if (hi_z > $signed({3'b0, sz}) - 9'sd1) hi_z = $signed({3'b0, sz}) - 9'sd1;
        px = {1'b0, i_req.probe_x};
        py = {1'b0, i_req.probe_y};
        pz = {1'b0, i_req.probe_z};

        o_job = '0;
        case (i_req.command)
            CMD_STAMP: begin
                // empty box becomes a no-op
                o_job.op = (lo_x > hi_x || lo_y > hi_y || lo_z > hi_z) ? OP_NOP : OP_STAMP;
            end
            CMD_READ:  o_job.op = OP_READ;
            CMD_CLEAR: o_job.op = OP_CLEAR;
            default:   o_job.op = OP_NOP;
        endcase
        o_job.x0  = lo_x[XW-1:0];
        o_job.x1  = hi_x[XW-1:0];
        o_job.y0  = lo_y[XW-1:0];
        o_job.y1  = hi_y[XW-1:0];
        o_job.z0  = lo_z[ZW-1:0];
        o_job.z1  = hi_z[ZW-1:0];
        o_job.cx  = i_req.ctr_x[XW-1:0];
        o_job.cy  = i_req.ctr_y[XW-1:0];
        o_job.cz  = i_req.ctr_z[ZW-1:0];
        o_job.r   = {1'b0, i_req.radius};
        o_job.oor = (px >= sxy) || (py >= sxy) || (pz >= sz);
        if (i_req.command == CMD_READ) begin
            o_job.x0 = i_req.probe_x[XW-1:0];
            o_job.y0 = i_req.probe_y[XW-1:0];
            o_job.z0 = i_req.probe_z[ZW-1:0];
        end
    end
endmodule

@@ src/svs_queue.sv @@
// short job queue between front and back end
// depends on svs_pkg
module svs_queue import svs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);
    t_job r_mem [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == 2'(QDEPTH));
endmodule

@@ src/svs_back.sv @@
// back end: column memory, stamp walker, read and clear sweep
// depends on svs_pkg
module svs_back import svs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);
    logic [MAX_Z-1:0] r_mem [DEPTH];
    logic [MAX_Z-1:0] r_rdata;
    t_bk_state r_state, n_state;
    t_job r_job;
    logic [XW-1:0] r_i, r_j;
    logic [AW-1:0] r_clr;
    logic r_clr_boot;
    logic [MAX_Z-1:0] r_bits;
    logic [13:0] r_dxy;
    logic [MAX_Z-1:0] bits;
    logic signed [XW+1:0] dx, dy;
    logic signed [ZW+1:0] dz;
    logic [13:0] r2;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [MAX_Z-1:0] wdata;
    logic last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_CLEAR;
        else r_state <= n_state;
    end

    assign last_col = (r_j == r_job.y1) && (r_i == r_job.x1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    case (i_job.op)
                        OP_STAMP: n_state = BK_RD;
                        OP_READ:  n_state = BK_READ;
                        OP_CLEAR: n_state = BK_CLEAR;
                        default:  n_state = BK_DONE;
                    endcase
                end
            end
            BK_RD:    n_state = BK_CALC;
            BK_CALC:  n_state = BK_WR;
            BK_WR:    n_state = last_col ? BK_DONE : BK_RD;
            BK_READ:  n_state = BK_DONE;
            BK_CLEAR: n_state = (r_clr == AW'(DEPTH - 1)) ?
                                (r_clr_boot ? BK_IDLE : BK_DONE) : BK_CLEAR;
            BK_DONE:  n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == BK_IDLE) && !i_empty;
        o_busy = (r_state != BK_IDLE);
        we     = (r_state == BK_WR) || (r_state == BK_CLEAR);
        waddr  = (r_state == BK_CLEAR) ? r_clr : {r_i, r_j};
        wdata  = (r_state == BK_CLEAR) ? '0 : (r_rdata | r_bits);
        raddr  = (r_state == BK_IDLE) ? {i_job.x0, i_job.y0} : {r_i, r_j};
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    // column distance and per-z mask
    always_comb begin
        dx = $signed({2'b0, r_i}) - $signed({2'b0, r_job.cx});
        dy = $signed({2'b0, r_j}) - $signed({2'b0, r_job.cy});
        r2 = 14'(r_job.r * r_job.r);
        bits = '0;
        for (int k = 0; k < MAX_Z; k++) begin
            dz = $signed((ZW+2)'(k)) - $signed({2'b0, r_job.cz});
            if ((ZW'(k) >= r_job.z0) && (ZW'(k) <= r_job.z1) &&
                (r_dxy + 14'(dz * dz) <= r2))
                bits[k] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_boot <= 1'b1;
            o_done     <= 1'b0;
        end else begin
            o_done <= (r_state == BK_DONE);
            if (r_state == BK_CLEAR) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) r_clr_boot <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_i   <= i_job.x0;
            r_j   <= i_job.y0;
        end
        if (r_state == BK_RD) r_dxy <= 14'(dx * dx) + 14'(dy * dy);
        if (r_state == BK_CALC) r_bits <= bits;
        if (r_state == BK_WR) begin
            if (r_j == r_job.y1) begin
                r_j <= r_job.y0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_state == BK_DONE) begin
            o_rsp.voxel_value  <= (r_job.op == OP_READ) && !r_job.oor &&
                                  r_rdata[r_job.z0];
            o_rsp.out_of_range <= (r_job.op == OP_READ) && r_job.oor;
        end
    end
endmodule
